/* sv/aavr_pkg.sv */
// ----------------------------------------------------------------------------
// Axis-angle rotation package
// Shared widths, constants, and payload types for the axis-angle rotation
// block.
// ----------------------------------------------------------------------------
`default_nettype none
package aavr_pkg;

    localparam int CordicSteps = 16;
    localparam int FracBits    = 16;

    localparam logic signed [47:0] Deg360 = 48'sd23592960;
    localparam logic signed [47:0] Deg270 = 48'sd17694720;
    localparam logic signed [47:0] Deg180 = 48'sd11796480;
    localparam logic signed [47:0] Deg90  = 48'sd5898240;

    // Whole-degree reduction: offset by a multiple of 360 to make the value
    // positive, then divide by 360 through a reciprocal in Q24.
    localparam logic [16:0] DegOffset  = 17'd33120;
    localparam logic [16:0] DegPerTurn = 17'd360;
    localparam logic [15:0] Recip360   = 16'd46604;

    localparam logic signed [31:0] RadPerDegQ30 = 32'sd18740330;
    localparam logic signed [33:0] CordicGain   = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [31:0] angle_deg;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } out_item_t;

    // Front result: the folded angle in radians with the quadrant signs.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [33:0] z_rad;
        logic               sneg;
        logic               cneg;
    } job_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] t;
        case (i)
            0:  t = 34'sd843314857;
            1:  t = 34'sd497837830;
            2:  t = 34'sd263043837;
            3:  t = 34'sd133525159;
            4:  t = 34'sd67021687;
            5:  t = 34'sd33543516;
            6:  t = 34'sd16775851;
            7:  t = 34'sd8388437;
            8:  t = 34'sd4194283;
            9:  t = 34'sd2097149;
            default: t = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

/* sv/aavr_if.sv */
// ----------------------------------------------------------------------------
// Axis-angle rotation stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface aavr_in_if;
    logic               valid;
    logic               ready;
    aavr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aavr_out_if;
    logic                valid;
    logic                ready;
    aavr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/aavr_front.sv */
// ----------------------------------------------------------------------------
// Axis-angle rotation front end
// Reduces the angle modulo 360, folds it into the first quadrant, and
// converts it to Q30 radians over a short pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module aavr_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    aavr_in_if.sink                  in_ch,
    output logic                     job_valid,
    output aavr_pkg::job_t           job,
    input  wire logic                advance
);
    // Stage 1: modulo; stage 2: fold; stage 3: radians.
    logic              v1_reg, v2_reg, v3_reg;
    aavr_pkg::in_item_t it1_reg, it2_reg, it3_reg;
    logic signed [47:0] r1_reg;
    logic signed [47:0] a2_reg;
    logic               sn2_reg, cn2_reg, sn3_reg, cn3_reg;
    logic signed [33:0] z3_reg;
    logic signed [47:0] r_next, a_next;
    logic signed [55:0] prod;
    logic               sn_next, cn_next;
    logic [16:0]        deg_off, deg_rem;
    logic [32:0]        deg_prod;
    logic [7:0]         deg_quot;

    assign in_ch.ready = advance;

    // The fraction bits pass through; only the whole degrees are reduced.
    always_comb
    begin
        deg_off  = {in_ch.data.angle_deg[31], in_ch.data.angle_deg[31:16]}
                   + aavr_pkg::DegOffset;
        deg_prod = 33'(deg_off) * 33'(aavr_pkg::Recip360);
        deg_quot = deg_prod[31:24];
        deg_rem  = deg_off - 17'(deg_quot) * aavr_pkg::DegPerTurn;
        r_next   = 48'({deg_rem[8:0], in_ch.data.angle_deg[15:0]});
    end

    always_comb
    begin
        sn_next = 1'b0;
        cn_next = 1'b0;
        if (r1_reg <= aavr_pkg::Deg90)
        begin
            a_next = r1_reg;
        end
        else if (r1_reg <= aavr_pkg::Deg180)
        begin
            a_next  = aavr_pkg::Deg180 - r1_reg;
            cn_next = 1'b1;
        end
        else if (r1_reg <= aavr_pkg::Deg270)
        begin
            a_next  = r1_reg - aavr_pkg::Deg180;
            sn_next = 1'b1;
            cn_next = 1'b1;
        end
        else
        begin
            a_next  = aavr_pkg::Deg360 - r1_reg;
            sn_next = 1'b1;
        end
    end

    assign prod = 56'(signed'({1'b0, a2_reg[23:0]})) * 56'(aavr_pkg::RadPerDegQ30)
                  + 56'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            it1_reg <= in_ch.data;
            r1_reg  <= r_next;
            it2_reg <= it1_reg;
            a2_reg  <= a_next;
            sn2_reg <= sn_next;
            cn2_reg <= cn_next;
            it3_reg <= it2_reg;
            z3_reg  <= 34'(prod >>> 16);
            sn3_reg <= sn2_reg;
            cn3_reg <= cn2_reg;
        end
    end

    assign job_valid   = v3_reg;
    assign job.point_x = it3_reg.point_x;
    assign job.point_y = it3_reg.point_y;
    assign job.point_z = it3_reg.point_z;
    assign job.axis_x  = it3_reg.axis_x;
    assign job.axis_y  = it3_reg.axis_y;
    assign job.axis_z  = it3_reg.axis_z;
    assign job.z_rad   = z3_reg;
    assign job.sneg    = sn3_reg;
    assign job.cneg    = cn3_reg;
endmodule
`default_nettype wire

/* sv/aavr_queue.sv */
// ----------------------------------------------------------------------------
// Axis-angle rotation job queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module aavr_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  aavr_pkg::job_t push_data,
    output logic           full,
    output logic           empty,
    input  wire logic      pop,
    output aavr_pkg::job_t pop_data
);
    aavr_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

/* sv/aavr_back.sv */
// ----------------------------------------------------------------------------
// Axis-angle rotation back end
// Unrolled CORDIC pipeline for sine and cosine, then the Rodrigues matrix
// and the matrix-vector product, with rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module aavr_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_valid,
    input  aavr_pkg::job_t job,
    output logic           job_take,
    aavr_out_if.source     out_ch
);
    localparam int N  = aavr_pkg::CordicSteps;
    localparam int FB = aavr_pkg::FracBits;
    localparam int NS = N + 6;

    logic advance;
    logic [NS-1:0] v_reg;

    // CORDIC stage registers.
    logic signed [33:0] cx_reg [N+1];
    logic signed [33:0] cy_reg [N+1];
    logic signed [33:0] cz_reg [N+1];
    aavr_pkg::job_t     cj_reg [N+1];

    // Post stages.
    aavr_pkg::job_t     j1_reg, j2_reg, j3_reg;
    logic signed [FB+1:0] s1_reg, c1_reg;
    logic signed [FB+1:0] s2_reg, c2_reg;
    logic signed [FB+2:0] omc1_reg, omc2_reg;
    logic signed [31:0] uu_reg [6];
    logic signed [FB+17:0] us_reg [3];
    logic signed [FB+1:0] c3_reg;
    logic signed [FB+17:0] uuo_reg [6];
    logic signed [FB+17:0] m_reg [9];
    logic signed [31:0] p4_reg [3];
    logic signed [FB+51:0] pr_reg [9];
    aavr_pkg::out_item_t res_reg;
    logic               ov_reg;

    logic signed [FB+1:0] s_fr, c_fr;

    assign advance  = !ov_reg || out_ch.ready;
    assign job_take = advance && job_valid;

    function automatic logic signed [FB+1:0] to_frac(input logic signed [33:0] q);
        logic signed [33:0] v;
        v = (q + (34'sd1 <<< (29 - FB))) >>> (30 - FB);
        if (v < 0)
        begin
            v = 34'sd0;
        end
        if (v > (34'sd1 <<< FB))
        begin
            v = 34'sd1 <<< FB;
        end
        return (FB+2)'(v);
    endfunction

    always_comb
    begin
        s_fr = to_frac(cy_reg[N]);
        c_fr = to_frac(cx_reg[N]);
        if (cj_reg[N].sneg)
        begin
            s_fr = -s_fr;
        end
        if (cj_reg[N].cneg)
        begin
            c_fr = -c_fr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NS-2:0], job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg[0] <= aavr_pkg::CordicGain;
            cy_reg[0] <= 34'sd0;
            cz_reg[0] <= job.z_rad;
            cj_reg[0] <= job;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                cj_reg[i+1] <= cj_reg[i];
                if (cz_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - aavr_pkg::atan_q30(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + aavr_pkg::atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // Sine and cosine in Q(FB).
            j1_reg   <= cj_reg[N];
            s1_reg   <= s_fr;
            c1_reg   <= c_fr;
            omc1_reg <= (FB+3)'(1 <<< FB) - c_fr;
            // Axis pair products.
            j2_reg   <= j1_reg;
            s2_reg   <= s1_reg;
            c2_reg   <= c1_reg;
            omc2_reg <= omc1_reg;
            uu_reg[0] <= j1_reg.axis_x * j1_reg.axis_x;
            uu_reg[1] <= j1_reg.axis_y * j1_reg.axis_y;
            uu_reg[2] <= j1_reg.axis_z * j1_reg.axis_z;
            uu_reg[3] <= j1_reg.axis_x * j1_reg.axis_y;
            uu_reg[4] <= j1_reg.axis_x * j1_reg.axis_z;
            uu_reg[5] <= j1_reg.axis_y * j1_reg.axis_z;
            // Pair products times one minus cosine, and axis times sine.
            j3_reg <= j2_reg;
            c3_reg <= c2_reg;
            us_reg[0] <= ((FB+18)'(j2_reg.axis_x) * (FB+18)'(s2_reg)
                          + (FB+18)'(8192)) >>> 14;
            us_reg[1] <= ((FB+18)'(j2_reg.axis_y) * (FB+18)'(s2_reg)
                          + (FB+18)'(8192)) >>> 14;
            us_reg[2] <= ((FB+18)'(j2_reg.axis_z) * (FB+18)'(s2_reg)
                          + (FB+18)'(8192)) >>> 14;
            for (int k = 0; k < 6; k++)
            begin
                uuo_reg[k] <= (FB+18)'(((FB+50)'(uu_reg[k]) * (FB+50)'(omc2_reg)
                               + (FB+50)'(1 <<< 27)) >>> 28);
            end
            // Matrix entries.
            m_reg[0] <= uuo_reg[0] + (FB+18)'(c3_reg);
            m_reg[4] <= uuo_reg[1] + (FB+18)'(c3_reg);
            m_reg[8] <= uuo_reg[2] + (FB+18)'(c3_reg);
            m_reg[1] <= uuo_reg[3] - us_reg[2];
            m_reg[3] <= uuo_reg[3] + us_reg[2];
            m_reg[2] <= uuo_reg[4] + us_reg[1];
            m_reg[6] <= uuo_reg[4] - us_reg[1];
            m_reg[5] <= uuo_reg[5] - us_reg[0];
            m_reg[7] <= uuo_reg[5] + us_reg[0];
            p4_reg[0] <= j3_reg.point_x;
            p4_reg[1] <= j3_reg.point_y;
            p4_reg[2] <= j3_reg.point_z;
            // Entry times coordinate.
            for (int k = 0; k < 9; k++)
            begin
                pr_reg[k] <= (FB+52)'(m_reg[k]) * (FB+52)'(p4_reg[k % 3]);
            end
        end
    end

    function automatic logic signed [31:0] sum_sat(input logic signed [FB+51:0] a,
                                                   input logic signed [FB+51:0] b,
                                                   input logic signed [FB+51:0] c);
        logic signed [FB+53:0] t;
        t = ((FB+54)'(a) + (FB+54)'(b) + (FB+54)'(c) + (FB+54)'(1 <<< (FB - 1))) >>> FB;
        if (t > (FB+54)'(32'sh7fffffff))
        begin
            return 32'sh7fffffff;
        end
        if (t < -(FB+54)'(64'sh80000000))
        begin
            return 32'sh80000000;
        end
        return 32'(t);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (advance)
        begin
            ov_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.rot_x <= sum_sat(pr_reg[0], pr_reg[1], pr_reg[2]);
            res_reg.rot_y <= sum_sat(pr_reg[3], pr_reg[4], pr_reg[5]);
            res_reg.rot_z <= sum_sat(pr_reg[6], pr_reg[7], pr_reg[8]);
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = res_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result changed while stalled");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid && advance) else $error("bad take");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v_reg[NS-1] |=> out_ch.valid) else $error("result lost");
`endif
endmodule
`default_nettype wire

/* sv/axis_angle_vector_rotation.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotation
// Rotates a Q16.16 point about a Q2.14 unit axis by an angle in degrees.
//
//   Channel  Direction  Payload
//   in_ch    sink       point_x/y/z, axis_x/y/z, angle_deg
//   out_ch   source     rot_x, rot_y, rot_z
//
// One transaction per cycle sustained while the output is not stalled. The
// front end registers modulo, fold and radians; the back end the CORDIC
// steps and post stages. Reset clears all valid flags. A stalled output holds
// the back end; the front end keeps running until the two-entry queue fills.
// ----------------------------------------------------------------------------
`default_nettype none
module axis_angle_vector_rotation (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aavr_in_if.sink    in_ch,
    aavr_out_if.source out_ch
);
    logic           f_valid, f_adv, q_full, q_empty, take;
    aavr_pkg::job_t f_job, q_job;

    assign f_adv = !q_full || !f_valid;

    aavr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job_valid (f_valid),
        .job       (f_job),
        .advance   (f_adv)
    );

    aavr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && !q_full),
        .push_data (f_job),
        .full      (q_full),
        .empty     (q_empty),
        .pop       (take),
        .pop_data  (q_job)
    );

    aavr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (q_job),
        .job_take  (take),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Axis-angle rotation testbench
// Drives points, axes and angles into the rotation block, predicts each
// rotated point with a fixed-point Rodrigues model, and compares every
// result transaction field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   sent_count;
    int   checked_count;
    bit   long_hold;
    bit   done;

    aavr_pkg::out_item_t rotated_q[$];

    aavr_in_if  in_ch ();
    aavr_out_if out_ch ();

    axis_angle_vector_rotation uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint frac_of_q30(longint q30);
        longint v;
        v = (q30 + (64'sd1 <<< (29 - aavr_pkg::FracBits))) >>> (30 - aavr_pkg::FracBits);
        if (v < 0)
            v = 0;
        if (v > (64'sd1 <<< aavr_pkg::FracBits))
            v = 64'sd1 <<< aavr_pkg::FracBits;
        return v;
    endfunction

    function automatic aavr_pkg::out_item_t rotate_point(aavr_pkg::in_item_t it);
        longint    p[3];
        longint    u[3];
        longint    m[3][3];
        longint    r, a, x, y, z, dx, dy, sn, cs, omc, acc, sx, sy, sz;
        bit        sneg, cneg;
        aavr_pkg::out_item_t res;
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        u[0] = it.axis_x;
        u[1] = it.axis_y;
        u[2] = it.axis_z;
        sneg = 0;
        cneg = 0;
        r = longint'(it.angle_deg) % longint'(aavr_pkg::Deg360);
        if (r < 0)
            r += aavr_pkg::Deg360;
        if (r <= aavr_pkg::Deg90)
            a = r;
        else if (r <= aavr_pkg::Deg180)
        begin
            a = aavr_pkg::Deg180 - r;
            cneg = 1;
        end
        else if (r <= aavr_pkg::Deg270)
        begin
            a = r - aavr_pkg::Deg180;
            sneg = 1;
            cneg = 1;
        end
        else
        begin
            a = aavr_pkg::Deg360 - r;
            sneg = 1;
        end
        z = (a * longint'(aavr_pkg::RadPerDegQ30) + 32768) >>> 16;
        x = aavr_pkg::CordicGain;
        y = 0;
        for (int i = 0; i < aavr_pkg::CordicSteps && i < 31; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(aavr_pkg::atan_q30(i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(aavr_pkg::atan_q30(i));
            end
        end
        cs = frac_of_q30(x);
        sn = frac_of_q30(y);
        if (cneg)
            cs = -cs;
        if (sneg)
            sn = -sn;
        omc = (64'sd1 <<< aavr_pkg::FracBits) - cs;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = round_shr(u[i] * u[j] * omc, 28);
        for (int i = 0; i < 3; i++)
            m[i][i] += cs;
        sx = round_shr(u[0] * sn, 14);
        sy = round_shr(u[1] * sn, 14);
        sz = round_shr(u[2] * sn, 14);
        m[0][1] -= sz;
        m[1][0] += sz;
        m[0][2] += sy;
        m[2][0] -= sy;
        m[1][2] -= sx;
        m[2][1] += sx;
        acc = m[0][0] * p[0] + m[0][1] * p[1] + m[0][2] * p[2];
        res.rot_x = clamp32(round_shr(acc, aavr_pkg::FracBits));
        acc = m[1][0] * p[0] + m[1][1] * p[1] + m[1][2] * p[2];
        res.rot_y = clamp32(round_shr(acc, aavr_pkg::FracBits));
        acc = m[2][0] * p[0] + m[2][1] * p[1] + m[2][2] * p[2];
        res.rot_z = clamp32(round_shr(acc, aavr_pkg::FracBits));
        return res;
    endfunction

    task automatic send_item(aavr_pkg::in_item_t it, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        rotated_q.push_back(rotate_point(it));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (rotated_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    function automatic aavr_pkg::in_item_t make_item(logic [31:0] px, logic [31:0] py,
                                                     logic [31:0] pz, logic [15:0] ax,
                                                     logic [15:0] ay, logic [15:0] az,
                                                     logic [31:0] ang);
        aavr_pkg::in_item_t it;
        it.point_x   = px;
        it.point_y   = py;
        it.point_z   = pz;
        it.axis_x    = ax;
        it.axis_y    = ay;
        it.axis_z    = az;
        it.angle_deg = ang;
        return it;
    endfunction

    function automatic logic [15:0] unit_comp();
        case ($urandom_range(0, 3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($urandom_range(0, 32767) - 16384);
        endcase
    endfunction

    function automatic aavr_pkg::in_item_t random_item();
        aavr_pkg::in_item_t it;
        logic [31:0] ang;
        it = make_item($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            it.point_x = $signed($urandom) >>> $urandom_range(0, 14);
            it.point_y = $signed($urandom) >>> $urandom_range(0, 14);
            it.point_z = $signed($urandom) >>> $urandom_range(0, 14);
            it.axis_x  = unit_comp();
            it.axis_y  = unit_comp();
            it.axis_z  = unit_comp();
            ang = ($urandom_range(0, 1440) - 720) * 65536;
            it.angle_deg = ($urandom_range(0, 1) == 0) ? ang : ($signed($urandom) >>> 8);
        end
        return it;
    endfunction

    task automatic test_directed();
        logic [31:0] angles[12];
        angles = '{32'sd0, 32'sd5898240, 32'sd11796480, 32'sd17694720, 32'sd23592960,
                   -32'sd5898240, -32'sd23592960, 32'sh7fffffff, 32'sh80000000,
                   32'sd2949120, 32'sd5898241, 32'sd17694719};
        foreach (angles[i])
            send_item(make_item(32'sd65536, 32'sd131072, -32'sd196608,
                                16'sd0, 16'sd0, 16'sd16384, angles[i]));
        send_item(make_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                            16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sd2949120));
        send_item(make_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                            16'sh8000, 16'sh8000, 16'sh8000, 32'sd11796480));
        send_item(make_item(32'sh80000000, 32'sh7fffffff, 32'sd0,
                            16'sd16384, 16'sd0, 16'sd0, 32'sd11796480));
        send_item(make_item(32'hffffffff, 32'h0, 32'h55555555,
                            16'hffff, 16'h0, 16'h5555, 32'haaaaaaaa));
        send_item(make_item(32'h0, 32'hffffffff, 32'haaaaaaaa,
                            16'h0, 16'hffff, 16'haaaa, 32'h55555555));
        send_item(make_item(32'sd1000000, -32'sd1000000, 32'sd12345,
                            16'sd9459, 16'sd9459, 16'sd9459, -32'sd7864320));
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_item(random_item());
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        repeat (60)
            send_item(random_item(), 1'b1);
        long_hold = 1'b0;
        wait_drained();
    endtask

    task automatic test_burst();
        repeat (200)
            send_item(random_item(), 1'b1);
    endtask

    initial
    begin
        mismatches     = 0;
        sent_count     = 0;
        checked_count  = 0;
        long_hold      = 1'b0;
        done           = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        wait_drained();
        test_random(500);
        test_backpressure();
        test_burst();
        test_random(450);
        wait_drained();
        repeat (40)
            @(negedge clk);
        $display("Sent %0d point transactions (directed angles, extremes, random axes),",
                 sent_count);
        $display("checked %0d rotated results under random and long output stalls.",
                 checked_count);
        if (mismatches == 0 && rotated_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (150)
                    @(negedge clk);
                while (long_hold)
                begin
                    out_ch.ready <= 1'b1;
                    @(negedge clk);
                end
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_cycles != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles - 1)
                    @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        aavr_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (rotated_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result transaction %h", $time, out_ch.data);
            end
            else
            begin
                want = rotated_q.pop_front();
                checked_count++;
                if (out_ch.data.rot_x !== want.rot_x)
                begin
                    mismatches++;
                    $display("%0t: rot_x expected %0d actual %0d", $time, want.rot_x,
                             out_ch.data.rot_x);
                end
                if (out_ch.data.rot_y !== want.rot_y)
                begin
                    mismatches++;
                    $display("%0t: rot_y expected %0d actual %0d", $time, want.rot_y,
                             out_ch.data.rot_y);
                end
                if (out_ch.data.rot_z !== want.rot_z)
                begin
                    mismatches++;
                    $display("%0t: rot_z expected %0d actual %0d", $time, want.rot_z,
                             out_ch.data.rot_z);
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
